@@ hw/rtl/mi3_pkg.sv @@
// Package for matrix_inverse_3x3: payload structs, widths, divider lane types.
// No dependencies.
package mi3_pkg;
    localparam int IN_W   = 16;
    localparam int OUT_W  = 32;
    localparam int ADJ_W  = 33;          // |adj| <= 2^31, signed
    localparam int DET_W  = 50;          // |det| < 2^48, signed
    localparam int MAG_W  = 49;          // divisor magnitude
    localparam int NUM_W  = 61;          // 2*|adj|<<28 fits 60 bits
    localparam int QW     = 33;          // quotient bits kept before clamp
    localparam int FRAC_SHIFT = 28;
    localparam int Q16_ONE = 32'h0001_0000;

    typedef struct packed {
        logic signed [IN_W-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
    } t_in;

    typedef struct packed {
        logic signed [OUT_W-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
        logic singular;
        logic saturated;
    } t_out;

    // per-item flags carried beside the divider lanes
    typedef struct packed {
        logic vld;
        logic singular;
    } t_tag;
endpackage

@@ hw/rtl/mi3_cof.sv @@
// Cofactor stage: registered products, adjugate entries, determinant.
// Depends on mi3_pkg.
module mi3_cof (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  mi3_pkg::t_in                      i_m,
    output logic signed [mi3_pkg::ADJ_W-1:0]  o_adj [9],
    output logic signed [mi3_pkg::DET_W-1:0]  o_det
);
    logic signed [31:0] r_p [18];
    logic signed [15:0] r_m0, r_m1, r_m2, r_n0, r_n1, r_n2;
    logic signed [mi3_pkg::ADJ_W-1:0] r_adj [9];
    logic signed [mi3_pkg::DET_W-1:0] n_det;
    logic signed [mi3_pkg::IN_W+mi3_pkg::ADJ_W-1:0] p_det0, p_det1, p_det2;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p[0]  <= i_m.a11 * i_m.a22; r_p[1]  <= i_m.a12 * i_m.a21;
            r_p[2]  <= i_m.a02 * i_m.a21; r_p[3]  <= i_m.a01 * i_m.a22;
            r_p[4]  <= i_m.a01 * i_m.a12; r_p[5]  <= i_m.a02 * i_m.a11;
            r_p[6]  <= i_m.a12 * i_m.a20; r_p[7]  <= i_m.a10 * i_m.a22;
            r_p[8]  <= i_m.a00 * i_m.a22; r_p[9]  <= i_m.a02 * i_m.a20;
            r_p[10] <= i_m.a02 * i_m.a10; r_p[11] <= i_m.a00 * i_m.a12;
            r_p[12] <= i_m.a10 * i_m.a21; r_p[13] <= i_m.a11 * i_m.a20;
            r_p[14] <= i_m.a01 * i_m.a20; r_p[15] <= i_m.a00 * i_m.a21;
            r_p[16] <= i_m.a00 * i_m.a11; r_p[17] <= i_m.a01 * i_m.a10;
            r_m0 <= i_m.a00; r_m1 <= i_m.a01; r_m2 <= i_m.a02;
            for (int k = 0; k < 9; k++) begin
                r_adj[k] <= mi3_pkg::ADJ_W'(r_p[2*k]) - mi3_pkg::ADJ_W'(r_p[2*k+1]);
            end
            r_n0 <= r_m0; r_n1 <= r_m1; r_n2 <= r_m2;
            o_det <= n_det;
            o_adj <= r_adj;
        end
    end

    // det = a00*adj0 + a01*adj3 + a02*adj6 (16x33 products)
    assign p_det0 = r_n0 * r_adj[0];
    assign p_det1 = r_n1 * r_adj[3];
    assign p_det2 = r_n2 * r_adj[6];
    assign n_det = mi3_pkg::DET_W'(p_det0) + mi3_pkg::DET_W'(p_det1)
                 + mi3_pkg::DET_W'(p_det2);
endmodule

@@ hw/rtl/mi3_div.sv @@
// Divider lane: pipelined restoring divide, one quotient bit per stage, rounding, clamp.
// Depends on mi3_pkg.
module mi3_div (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic signed [mi3_pkg::ADJ_W-1:0] i_adj,
    input  logic signed [mi3_pkg::DET_W-1:0] i_det,
    output logic        [mi3_pkg::OUT_W-1:0] o_q,
    output logic                             o_sat
);
    localparam int S = mi3_pkg::QW;
    // q = floor((2n+d)/(2d)); quotient < 2^33 after clamp check (larger treated as sat)
    logic [mi3_pkg::NUM_W:0]   r_rem [S+1];
    logic [mi3_pkg::MAG_W:0]   r_den [S+1];
    logic [S-1:0]              r_q   [S+1];
    logic                      r_neg [S+1];
    logic                      r_big [S+1];
    logic [mi3_pkg::MAG_W-1:0] dmag;
    logic [31:0]               amag;
    logic [mi3_pkg::NUM_W:0]   num0;

    assign dmag = i_det[mi3_pkg::DET_W-1] ? mi3_pkg::MAG_W'(-i_det) : mi3_pkg::MAG_W'(i_det);
    assign amag = i_adj[mi3_pkg::ADJ_W-1] ? 32'(-i_adj) : 32'(i_adj);
    assign num0 = ({30'd0, amag} << (mi3_pkg::FRAC_SHIFT + 1)) + {13'd0, dmag};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= num0;
            r_den[0] <= {dmag, 1'b0};
            r_q[0]   <= '0;
            r_neg[0] <= i_adj[mi3_pkg::ADJ_W-1] ^ i_det[mi3_pkg::DET_W-1];
            // quotient >= 2^33 means overflow for sure
            r_big[0] <= (num0 >> S) >= {12'd0, dmag, 1'b0};
            for (int s = 0; s < S; s++) begin
                if ((r_rem[s] >> (S-1-s)) >= {12'd0, r_den[s]}) begin
                    r_rem[s+1] <= r_rem[s] - ({12'd0, r_den[s]} << (S-1-s));
                    r_q[s+1]   <= r_q[s] | (S'(1) << (S-1-s));
                end else begin
                    r_rem[s+1] <= r_rem[s];
                    r_q[s+1]   <= r_q[s];
                end
                r_den[s+1] <= r_den[s];
                r_neg[s+1] <= r_neg[s];
                r_big[s+1] <= r_big[s];
            end
            if (r_neg[S]) begin
                o_sat <= r_big[S] || r_q[S] > S'(33'h0_8000_0000);
                o_q   <= (r_big[S] || r_q[S] > S'(33'h0_8000_0000)) ? 32'h8000_0000
                         : 32'(-r_q[S]);
            end else begin
                o_sat <= r_big[S] || r_q[S] > S'(33'h0_7FFF_FFFF);
                o_q   <= (r_big[S] || r_q[S] > S'(33'h0_7FFF_FFFF)) ? 32'h7FFF_FFFF
                         : r_q[S][31:0];
            end
        end
    end
endmodule

@@ hw/rtl/matrix_inverse_3x3.sv @@
// Channel | dir | handshake           | payload
// in      | in  | i_valid / o_ready   | i_data (mi3_pkg::t_in)
// out     | out | o_valid / i_ready   | o_data (mi3_pkg::t_out)
// Fully pipelined: one request per cycle unless the output stalls; 39 register stages
// from accept to o_data: products, adjugate, det (3); divider load, 33 bit stages,
// round/clamp (35); merge (1).
// Pipeline advances whenever the output register is empty or being taken.
// Synchronous active-low reset clears valid bits only.
// Top level: cofactor stage, nine divider lanes, merging output register.
// Depends on mi3_pkg, mi3_cof, mi3_div.
module matrix_inverse_3x3 (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  mi3_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output mi3_pkg::t_out o_data
);
    localparam int LAT = 3 + mi3_pkg::QW + 1;   // cycles from accept to lane outputs
    logic en;
    logic signed [mi3_pkg::ADJ_W-1:0] adj [9];
    logic signed [mi3_pkg::DET_W-1:0] det;
    logic [mi3_pkg::OUT_W-1:0] q [9];
    logic [8:0] sat;
    mi3_pkg::t_tag r_tag [LAT+1];
    mi3_pkg::t_out n_out;

    // stall-all pipeline; output slot frees when taken
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    mi3_cof u_cof (.i_clk, .i_en(en), .i_m(i_data), .o_adj(adj), .o_det(det));

    for (genvar g = 0; g < 9; g++) begin : g_lane
        mi3_div u_div (.i_clk, .i_en(en), .i_adj(adj[g]), .i_det(det),
                       .o_q(q[g]), .o_sat(sat[g]));
    end

    // tag line: valid and singular follow the data down the pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= LAT; s++) r_tag[s].vld <= 1'b0;
            o_valid <= 1'b0;
        end else if (en) begin
            r_tag[0].vld      <= i_valid;
            r_tag[0].singular <= 1'b0;
            r_tag[3].singular <= (det == '0);   // det valid when tag sits at stage 2
            for (int s = 0; s < LAT; s++) begin
                r_tag[s+1].vld <= r_tag[s].vld;
                if (s != 2) r_tag[s+1].singular <= r_tag[s].singular;
            end
            o_valid <= r_tag[LAT].vld;
            o_data  <= n_out;
        end
    end

    // merge: identity on singular, else lane results and OR of clamp flags
    always_comb begin
        n_out.singular  = r_tag[LAT].singular;
        n_out.saturated = !r_tag[LAT].singular && (|sat);
        n_out.r00 = r_tag[LAT].singular ? mi3_pkg::Q16_ONE : q[0];
        n_out.r01 = r_tag[LAT].singular ? '0 : q[1];
        n_out.r02 = r_tag[LAT].singular ? '0 : q[2];
        n_out.r10 = r_tag[LAT].singular ? '0 : q[3];
        n_out.r11 = r_tag[LAT].singular ? mi3_pkg::Q16_ONE : q[4];
        n_out.r12 = r_tag[LAT].singular ? '0 : q[5];
        n_out.r20 = r_tag[LAT].singular ? '0 : q[6];
        n_out.r21 = r_tag[LAT].singular ? '0 : q[7];
        n_out.r22 = r_tag[LAT].singular ? mi3_pkg::Q16_ONE : q[8];
    end
endmodule

@@ hw/rtl/mi3_chk.sv @@
// Port checker for matrix_inverse_3x3 with bind. Depends on mi3_pkg.
module mi3_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input logic          o_ready,
    input logic          o_valid,
    input logic          i_ready,
    input mi3_pkg::t_out o_data
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data)) else $error("out hold");
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready) else $error("ready low with empty output");
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_data.singular && o_data.saturated)) else $error("flags");
    a_ident: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.singular |-> o_data.r00 == 32'h0001_0000 && o_data.r01 == 0)
        else $error("identity");
endmodule

bind matrix_inverse_3x3 mi3_chk u_chk (.*);

@@ tb/sv/tb_top.sv @@
// Testbench for matrix_inverse_3x3: streams 3x3 Q4.12 matrices, predicts the
// Q16.16 inverse with saturation/singular flags, and checks every result in order.
// Depends on mi3_pkg and the matrix_inverse_3x3 RTL.
`timescale 1ns / 100ps

module tb_top;
    localparam int LATENCY   = 39;
    localparam int MAX_CYCLES = 400000;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_valid;
    logic          o_ready;
    mi3_pkg::t_in  i_data;
    logic          o_valid;
    logic          i_ready;
    mi3_pkg::t_out o_data;

    matrix_inverse_3x3 DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    // 12 ns clock
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    mi3_pkg::t_out expected_inverses[$];
    int   error_count;
    int   cycle_count;
    bit   stim_done;

    // Rounded quotient of one adjugate entry over det, as signed Q16.16.
    // Rounds magnitudes half away from zero, then clamps to 32 bits.
    function automatic logic [31:0] q16_quotient(input longint adj, input longint det,
                                                 inout bit sat);
        bit     neg;
        longint unsigned num;
        longint unsigned den;
        longint unsigned q;
        neg = (adj < 0) != (det < 0);
        num = (adj < 0 ? -adj : adj) << 28;
        den = det < 0 ? -det : det;
        q = (2 * num + den) / (2 * den);
        if (!neg) begin
            if (q > 64'h7FFF_FFFF) begin
                q = 64'h7FFF_FFFF;
                sat = 1'b1;
            end
            return q[31:0];
        end
        if (q > 64'h8000_0000) begin
            q = 64'h8000_0000;
            sat = 1'b1;
        end
        q = -q;
        return q[31:0];
    endfunction

    function automatic mi3_pkg::t_out invert_matrix(input mi3_pkg::t_in a);
        longint m[9];
        longint adj[9];
        longint det;
        logic [31:0] r[9];
        bit     sat;
        mi3_pkg::t_out res;
        m[0] = a.a00; m[1] = a.a01; m[2] = a.a02;
        m[3] = a.a10; m[4] = a.a11; m[5] = a.a12;
        m[6] = a.a20; m[7] = a.a21; m[8] = a.a22;
        adj[0] =  (m[4] * m[8] - m[5] * m[7]);
        adj[1] = -(m[1] * m[8] - m[2] * m[7]);
        adj[2] =  (m[1] * m[5] - m[2] * m[4]);
        adj[3] = -(m[3] * m[8] - m[5] * m[6]);
        adj[4] =  (m[0] * m[8] - m[2] * m[6]);
        adj[5] = -(m[0] * m[5] - m[2] * m[3]);
        adj[6] =  (m[3] * m[7] - m[4] * m[6]);
        adj[7] = -(m[0] * m[7] - m[1] * m[6]);
        adj[8] =  (m[0] * m[4] - m[1] * m[3]);
        det = m[0] * adj[0] + m[1] * adj[3] + m[2] * adj[6];
        sat = 1'b0;
        if (det == 0) begin
            foreach (r[i]) r[i] = (i % 4 == 0) ? 32'(mi3_pkg::Q16_ONE) : 32'd0;
        end else begin
            foreach (r[i]) r[i] = q16_quotient(adj[i], det, sat);
        end
        res.r00 = r[0]; res.r01 = r[1]; res.r02 = r[2];
        res.r10 = r[3]; res.r11 = r[4]; res.r12 = r[5];
        res.r20 = r[6]; res.r21 = r[7]; res.r22 = r[8];
        res.singular  = (det == 0);
        res.saturated = sat;
        return res;
    endfunction

    // Sends one matrix after a random gap if allowed; prediction queued on acceptance.
    // Valid stays high into the next request when there is no gap.
    task automatic send_matrix(input mi3_pkg::t_in a, input bit allow_gap);
        int gap;
        gap = allow_gap ? $urandom_range(0, 13) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= a;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        expected_inverses.push_back(invert_matrix(a));
    endtask

    function automatic mi3_pkg::t_in make_matrix(input int v[9]);
        mi3_pkg::t_in a;
        a = {16'(v[0]), 16'(v[1]), 16'(v[2]), 16'(v[3]), 16'(v[4]),
             16'(v[5]), 16'(v[6]), 16'(v[7]), 16'(v[8])};
        return a;
    endfunction

    function automatic logic [15:0] rand_elem(input int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 8) - 4);        // tiny values
            2: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            default: return 16'($urandom_range(0, 16384) - 8192);
        endcase
    endfunction

    // Extremes, identity, singular, saturating and rounding cases.
    task automatic test_directed();
        send_matrix(make_matrix('{4096, 0, 0, 0, 4096, 0, 0, 0, 4096}), 1);
        send_matrix(make_matrix('{0, 0, 0, 0, 0, 0, 0, 0, 0}), 1);
        send_matrix(make_matrix('{1, 2, 3, 2, 4, 6, 7, 8, 9}), 1);       // rank 2
        send_matrix(make_matrix('{1, 0, 0, 0, 1, 0, 0, 0, 1}), 1);       // huge inverse
        send_matrix(make_matrix('{-1, 0, 0, 0, -1, 0, 0, 0, -1}), 1);
        send_matrix(make_matrix('{32767, 0, 0, 0, 32767, 0, 0, 0, 32767}), 1);
        send_matrix(make_matrix('{-32768, 0, 0, 0, -32768, 0, 0, 0, -32768}), 0);
        send_matrix(make_matrix('{-32768, 32767, -32768, 32767, -32768, 32767,
                                  -32768, -32768, 32767}), 0);
        send_matrix(make_matrix('{-32768, -32768, -32768, -32768, -32768, -32768,
                                  -32768, -32768, -32768}), 0);
        send_matrix(make_matrix('{32767, 32767, 32767, 32767, 32767, 32767,
                                  32767, 32767, 32767}), 0);
        send_matrix(make_matrix('{8192, 4096, 0, 4096, 8192, 4096, 0, 4096, 8192}), 1);
        send_matrix(make_matrix('{12288, 0, 0, 0, 12288, 0, 0, 0, 12288}), 1); // 1/3
        send_matrix(make_matrix('{3, 0, 0, 0, 1, 0, 0, 0, 1}), 1);       // inexact rounding
        send_matrix(make_matrix('{0, 4096, 0, 4096, 0, 0, 0, 0, 4096}), 1);
        send_matrix(make_matrix('{2, 0, 0, 0, -2, 0, 0, 0, 1}), 1);      // mixed signs
        send_matrix(make_matrix('{-32768, 1, 0, 0, 32767, -1, 5, 0, 2}), 1);
    endtask

    // Random matrices; gaps on some items, back-to-back streams on others.
    task automatic test_random(input int count);
        int mode;
        int v[9];
        bit burst;
        for (int n = 0; n < count; n++) begin
            if (n % 50 == 0) burst = $urandom_range(0, 2) == 0;
            mode = $urandom_range(0, 5);
            foreach (v[k]) v[k] = int'(signed'(rand_elem(mode > 3 ? 0 : mode)));
            if ($urandom_range(0, 9) == 0) begin
                for (int k = 0; k < 3; k++) v[3 + k] = v[k];   // force singular
            end
            send_matrix(make_matrix(v), !burst);
        end
    endtask

    // Result checker; random backpressure is driven below
    always @(posedge i_clk) begin
        mi3_pkg::t_out exp_res;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_inverses.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_data);
                error_count++;
            end else begin
                exp_res = expected_inverses.pop_front();
                if (o_data.r00 !== exp_res.r00) begin
                    $display("%0t: r00 expected %h actual %h", $time, exp_res.r00, o_data.r00);
                    error_count++;
                end
                if (o_data.r01 !== exp_res.r01) begin
                    $display("%0t: r01 expected %h actual %h", $time, exp_res.r01, o_data.r01);
                    error_count++;
                end
                if (o_data.r02 !== exp_res.r02) begin
                    $display("%0t: r02 expected %h actual %h", $time, exp_res.r02, o_data.r02);
                    error_count++;
                end
                if (o_data.r10 !== exp_res.r10) begin
                    $display("%0t: r10 expected %h actual %h", $time, exp_res.r10, o_data.r10);
                    error_count++;
                end
                if (o_data.r11 !== exp_res.r11) begin
                    $display("%0t: r11 expected %h actual %h", $time, exp_res.r11, o_data.r11);
                    error_count++;
                end
                if (o_data.r12 !== exp_res.r12) begin
                    $display("%0t: r12 expected %h actual %h", $time, exp_res.r12, o_data.r12);
                    error_count++;
                end
                if (o_data.r20 !== exp_res.r20) begin
                    $display("%0t: r20 expected %h actual %h", $time, exp_res.r20, o_data.r20);
                    error_count++;
                end
                if (o_data.r21 !== exp_res.r21) begin
                    $display("%0t: r21 expected %h actual %h", $time, exp_res.r21, o_data.r21);
                    error_count++;
                end
                if (o_data.r22 !== exp_res.r22) begin
                    $display("%0t: r22 expected %h actual %h", $time, exp_res.r22, o_data.r22);
                    error_count++;
                end
                if (o_data.singular !== exp_res.singular) begin
                    $display("%0t: singular expected %b actual %b", $time,
                             exp_res.singular, o_data.singular);
                    error_count++;
                end
                if (o_data.saturated !== exp_res.saturated) begin
                    $display("%0t: saturated expected %b actual %b", $time,
                             exp_res.saturated, o_data.saturated);
                    error_count++;
                end
            end
        end
    end

    // Receiver stall: random wait per result, with unstalled stretches.
    initial begin
        int wait_cycles;
        i_ready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (($urandom_range(0, 3) == 0) || stim_done) begin
                i_ready <= 1'b1;
                repeat ($urandom_range(20, 60)) @(posedge i_clk);
            end else begin
                wait_cycles = $urandom_range(0, 13);
                if (wait_cycles > 0) begin
                    i_ready <= 1'b0;
                    repeat (wait_cycles) @(posedge i_clk);
                end
                i_ready <= 1'b1;
                @(posedge i_clk);
                while (!o_valid) @(posedge i_clk);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > MAX_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        error_count = 0;
        cycle_count = 0;
        stim_done = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data  = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(1200);
        i_valid <= 1'b0;
        stim_done = 1'b1;
        while (expected_inverses.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (error_count == 0 && expected_inverses.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
